@@ rtl/core/nswdp_pkg.sv @@
package nswdp_pkg;

    localparam int SIG_W = 128;

    localparam logic [63:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic mul_start;
        logic mul_sel_p;
        logic add_start;
        logic add_sel_c;
        logic nan_set;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic add_done;
        logic z_nan;
        logic last;
        logic out_busy;
    } sts_t;

    function automatic logic is_nan(input logic [63:0] d);
        return (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] d);
        return (d[62:52] == 11'h7FF) && (d[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] d);
        return d[62:0] == 63'd0;
    endfunction

    function automatic logic [63:0] canon(input logic [63:0] d);
        return is_nan(d) ? CANON_NAN : d;
    endfunction

    // leading zero count, 128 for an all-zero word
    function automatic logic [7:0] lzc(input logic [SIG_W-1:0] v);
        logic [7:0] n;
        logic       found;
        n     = 8'd128;
        found = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 8'(SIG_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // right shift, lost bits jammed into the lsb
    function automatic logic [SIG_W-1:0] shr_sticky(input logic [SIG_W-1:0] v,
                                                    input logic [7:0] amt);
        logic [SIG_W-1:0] r;
        logic [SIG_W-1:0] m;
        if (amt[7]) begin
            return {{(SIG_W-1){1'b0}}, |v};
        end
        r = v >> amt[6:0];
        m = ~({SIG_W{1'b1}} << amt[6:0]);
        return {r[SIG_W-1:1], r[0] | (|(v & m))};
    endfunction

    // sig has its leading one at the msb; er is the biased exponent of that one
    function automatic logic [63:0] round_pack(input logic sgn,
                                               input logic signed [13:0] er,
                                               input logic [SIG_W-1:0] sig);
        logic [SIG_W-1:0]   sh;
        logic [10:0]        ef;
        logic signed [13:0] dn;
        logic [7:0]         amt;
        logic               inc;
        logic [62:0]        body;
        if (er >= 14'sd2047) begin
            return {sgn, 11'h7FF, 52'd0};
        end
        if (er >= 14'sd1) begin
            sh = sig;
            ef = er[10:0];
        end
        else begin
            dn  = 14'sd1 - er;
            amt = (dn > 14'sd128) ? 8'd128 : dn[7:0];
            sh  = shr_sticky(sig, amt);
            ef  = 11'd0;
        end
        inc  = sh[74] & ((|sh[73:0]) | sh[75]);
        body = {ef, sh[126:75]} + 63'(inc);
        return {sgn, body};
    endfunction

endpackage

@@ rtl/core/nswdp_if.sv @@
interface nswdp_row_if;
    logic        valid;
    logic        ready;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic [63:0] weight_bits;
    logic        last_row;

    modport source (output valid, x_bits, y_bits, weight_bits, last_row, input ready);
    modport sink (input valid, x_bits, y_bits, weight_bits, last_row, output ready);
endinterface

interface nswdp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] sum_bits;
    logic [63:0] count_bits;
    logic        nan_seen;

    modport source (output valid, sum_bits, count_bits, nan_seen, input ready);
    modport sink (input valid, sum_bits, count_bits, nan_seen, output ready);
endinterface

@@ rtl/core/nswdp_fmul.sv @@
module nswdp_fmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);

    localparam logic [2:0] ST_PP0   = 3'd0;
    localparam logic [2:0] ST_PP1   = 3'd1;
    localparam logic [2:0] ST_PP2   = 3'd2;
    localparam logic [2:0] ST_PP3   = 3'd3;
    localparam logic [2:0] ST_LZC   = 3'd4;
    localparam logic [2:0] ST_SHIFT = 3'd5;
    localparam logic [2:0] ST_ROUND = 3'd6;

    logic        busy_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic [105:0] acc_reg;
    logic [7:0]  lz_reg;
    logic [nswdp_pkg::SIG_W-1:0] sig_reg;
    logic signed [13:0] er_reg;
    logic [63:0] res_reg;

    logic [10:0] ea_eff;
    logic [10:0] eb_eff;
    logic [52:0] ma;
    logic [52:0] mb;
    logic [26:0] op_a;
    logic [26:0] op_b;
    logic [53:0] pp;
    logic [6:0]  pp_sh;
    logic [105:0] acc_next;
    logic [nswdp_pkg::SIG_W-1:0] acc_ext;
    logic signed [13:0] er_next;
    logic        sgn;
    logic [63:0] res_next;

    assign ea_eff  = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    assign eb_eff  = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    assign ma      = {|a[62:52], a[51:0]};
    assign mb      = {|b[62:52], b[51:0]};
    assign sgn     = a[63] ^ b[63];
    assign acc_ext = {acc_reg, 22'd0};

    always_comb
    begin
        case (step_reg)
            ST_PP1:
            begin
                op_a  = ma[26:0];
                op_b  = {1'b0, mb[52:27]};
                pp_sh = 7'd27;
            end
            ST_PP2:
            begin
                op_a  = {1'b0, ma[52:27]};
                op_b  = mb[26:0];
                pp_sh = 7'd27;
            end
            ST_PP3:
            begin
                op_a  = {1'b0, ma[52:27]};
                op_b  = {1'b0, mb[52:27]};
                pp_sh = 7'd54;
            end
            default:
            begin
                op_a  = ma[26:0];
                op_b  = mb[26:0];
                pp_sh = 7'd0;
            end
        endcase
    end

    assign pp       = op_a * op_b;
    assign acc_next = acc_reg + (106'(pp) << pp_sh);
    assign er_next  = $signed(14'(ea_eff) + 14'(eb_eff) - 14'd1022 - 14'(lz_reg));

    always_comb
    begin
        if (nswdp_pkg::is_nan(a) || nswdp_pkg::is_nan(b)
            || (nswdp_pkg::is_inf(a) && nswdp_pkg::is_zero(b))
            || (nswdp_pkg::is_zero(a) && nswdp_pkg::is_inf(b))) begin
            res_next = nswdp_pkg::CANON_NAN;
        end
        else if (nswdp_pkg::is_inf(a) || nswdp_pkg::is_inf(b)) begin
            res_next = {sgn, 11'h7FF, 52'd0};
        end
        else if (nswdp_pkg::is_zero(a) || nswdp_pkg::is_zero(b)) begin
            res_next = {sgn, 63'd0};
        end
        else begin
            res_next = nswdp_pkg::round_pack(sgn, er_reg, sig_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= ST_PP0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= ST_PP0;
            end
            else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == ST_ROUND) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            acc_reg <= '0;
        end
        else if (busy_reg) begin
            case (step_reg) inside
                ST_PP0, ST_PP1, ST_PP2, ST_PP3: acc_reg <= acc_next;
                ST_LZC:   lz_reg <= nswdp_pkg::lzc(acc_ext);
                ST_SHIFT:
                begin
                    sig_reg <= acc_ext << lz_reg;
                    er_reg  <= er_next;
                end
                ST_ROUND: res_reg <= res_next;
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/core/nswdp_fadd.sv @@
module nswdp_fadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);

    localparam logic [2:0] ST_ALIGN = 3'd0;
    localparam logic [2:0] ST_SHR   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_LZC   = 3'd3;
    localparam logic [2:0] ST_NORM  = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;

    logic        busy_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic        sbig_reg;
    logic        sub_reg;
    logic        rsign_reg;
    logic        zero_reg;
    logic [10:0] ebig_reg;
    logic [7:0]  d_reg;
    logic [nswdp_pkg::SIG_W-1:0] abig_reg;
    logic [nswdp_pkg::SIG_W-1:0] bsm_reg;
    logic [nswdp_pkg::SIG_W-1:0] sum_reg;
    logic [nswdp_pkg::SIG_W-1:0] sig_reg;
    logic [7:0]  lz_reg;
    logic signed [13:0] er_reg;
    logic [63:0] res_reg;

    logic [10:0] ea_eff;
    logic [10:0] eb_eff;
    logic [52:0] ma;
    logic [52:0] mb;
    logic        a_big;
    logic [10:0] ebig;
    logic [10:0] ediff;
    logic [nswdp_pkg::SIG_W-1:0] sum_next;
    logic [63:0] res_next;

    assign ea_eff = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    assign eb_eff = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    assign ma     = {|a[62:52], a[51:0]};
    assign mb     = {|b[62:52], b[51:0]};
    assign a_big  = a[62:0] >= b[62:0];
    assign ebig   = a_big ? ea_eff : eb_eff;
    assign ediff  = a_big ? (ea_eff - eb_eff) : (eb_eff - ea_eff);

    assign sum_next = sub_reg ? (abig_reg - bsm_reg) : (abig_reg + bsm_reg);

    always_comb
    begin
        if (nswdp_pkg::is_nan(a) || nswdp_pkg::is_nan(b)
            || (nswdp_pkg::is_inf(a) && nswdp_pkg::is_inf(b) && (a[63] != b[63]))) begin
            res_next = nswdp_pkg::CANON_NAN;
        end
        else if (nswdp_pkg::is_inf(a)) begin
            res_next = a;
        end
        else if (nswdp_pkg::is_inf(b)) begin
            res_next = b;
        end
        else if (zero_reg) begin
            res_next = {rsign_reg, 63'd0};
        end
        else begin
            res_next = nswdp_pkg::round_pack(rsign_reg, er_reg, sig_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= ST_ALIGN;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= ST_ALIGN;
            end
            else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == ST_ROUND) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start) begin
            case (step_reg)
                ST_ALIGN:
                begin
                    sbig_reg <= a_big ? a[63] : b[63];
                    sub_reg  <= a[63] ^ b[63];
                    ebig_reg <= ebig;
                    d_reg    <= (ediff >= 11'd128) ? 8'd128 : ediff[7:0];
                    abig_reg <= {1'b0, (a_big ? ma : mb), 74'd0};
                    bsm_reg  <= {1'b0, (a_big ? mb : ma), 74'd0};
                end
                ST_SHR: bsm_reg <= nswdp_pkg::shr_sticky(bsm_reg, d_reg);
                ST_ADD:
                begin
                    sum_reg   <= sum_next;
                    zero_reg  <= sum_next == '0;
                    rsign_reg <= (sum_next == '0) ? (a[63] & b[63]) : sbig_reg;
                end
                ST_LZC: lz_reg <= nswdp_pkg::lzc(sum_reg);
                ST_NORM:
                begin
                    sig_reg <= sum_reg << lz_reg;
                    er_reg  <= $signed(14'(ebig_reg) + 14'd1 - 14'(lz_reg));
                end
                ST_ROUND: res_reg <= res_next;
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/core/nswdp_ctrl.sv @@
module nswdp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              row_fire,
    output logic              row_ready,
    input  nswdp_pkg::sts_t   sts,
    output nswdp_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        IDLE,
        MUL_Z,
        MUL_P,
        ADD_S,
        ADD_C,
        FIN
    } state_t;

    state_t          state_reg;
    nswdp_pkg::cmd_t cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= IDLE;
            cmd_reg   <= '0;
        end
        else begin
            cmd_reg <= '0;
            unique case (state_reg)
                IDLE:
                begin
                    if (row_fire) begin
                        cmd_reg.mul_start <= 1'b1;
                        cmd_reg.mul_sel_p <= 1'b0;
                        state_reg         <= MUL_Z;
                    end
                end
                MUL_Z:
                begin
                    if (sts.mul_done) begin
                        if (sts.z_nan) begin
                            cmd_reg.nan_set <= 1'b1;
                            state_reg       <= FIN;
                        end
                        else begin
                            cmd_reg.mul_start <= 1'b1;
                            cmd_reg.mul_sel_p <= 1'b1;
                            state_reg         <= MUL_P;
                        end
                    end
                end
                MUL_P:
                begin
                    if (sts.mul_done) begin
                        cmd_reg.add_start <= 1'b1;
                        cmd_reg.add_sel_c <= 1'b0;
                        state_reg         <= ADD_S;
                    end
                end
                ADD_S:
                begin
                    if (sts.add_done) begin
                        cmd_reg.add_start <= 1'b1;
                        cmd_reg.add_sel_c <= 1'b1;
                        state_reg         <= ADD_C;
                    end
                end
                ADD_C:
                begin
                    if (sts.add_done) begin
                        state_reg <= FIN;
                    end
                end
                FIN:
                begin
                    if (!sts.last) begin
                        state_reg <= IDLE;
                    end
                    else if (!sts.out_busy) begin
                        cmd_reg.emit <= 1'b1;
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign row_ready = state_reg == IDLE;
    assign cmd       = cmd_reg;

endmodule

@@ rtl/core/nswdp_dp.sv @@
module nswdp_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              row_fire,
    input  logic [63:0]       x_bits,
    input  logic [63:0]       y_bits,
    input  logic [63:0]       weight_bits,
    input  logic              last_row,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  nswdp_pkg::cmd_t   cmd,
    output nswdp_pkg::sts_t   sts,
    nswdp_res_if.source       result
);

    logic        use_w_reg;
    logic        nan_reg;
    logic [63:0] sum_reg;
    logic [63:0] count_reg;
    logic        out_valid_reg;
    logic [63:0] out_sum_reg;
    logic [63:0] out_count_reg;
    logic        out_nan_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] w_reg;
    logic        last_reg;
    logic [63:0] z_reg;
    logic [63:0] p_reg;
    logic        mul_sel_reg;
    logic        add_sel_reg;

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_res;
    logic        mul_done;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic [63:0] add_res;
    logic        add_done;

    assign mul_a = mul_sel_reg ? z_reg : x_reg;
    assign mul_b = mul_sel_reg ? w_reg : y_reg;
    assign add_a = add_sel_reg ? count_reg : sum_reg;
    assign add_b = add_sel_reg ? w_reg : p_reg;

    nswdp_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    nswdp_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.add_start),
        .a     (add_a),
        .b     (add_b),
        .done  (add_done),
        .res   (add_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            use_w_reg     <= 1'b0;
            nan_reg       <= 1'b0;
            sum_reg       <= nswdp_pkg::DBL_ZERO;
            count_reg     <= nswdp_pkg::DBL_ZERO;
            out_valid_reg <= 1'b0;
            mul_sel_reg   <= 1'b0;
            add_sel_reg   <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                use_w_reg <= cfg_wdata;
            end
            if (cmd.mul_start) begin
                mul_sel_reg <= cmd.mul_sel_p;
            end
            if (cmd.add_start) begin
                add_sel_reg <= cmd.add_sel_c;
            end
            if (add_done) begin
                if (add_sel_reg) begin
                    count_reg <= add_res;
                end
                else begin
                    sum_reg <= add_res;
                end
            end
            if (cmd.nan_set) begin
                nan_reg <= 1'b1;
            end
            if (result.valid && result.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= nswdp_pkg::DBL_ZERO;
                count_reg     <= nswdp_pkg::DBL_ZERO;
                nan_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_fire) begin
            x_reg    <= x_bits;
            y_reg    <= y_bits;
            w_reg    <= use_w_reg ? weight_bits : nswdp_pkg::DBL_ONE;
            last_reg <= last_row;
        end
        if (mul_done) begin
            if (mul_sel_reg) begin
                p_reg <= mul_res;
            end
            else begin
                z_reg <= mul_res;
            end
        end
        if (cmd.emit) begin
            out_sum_reg   <= nswdp_pkg::canon(sum_reg);
            out_count_reg <= nswdp_pkg::canon(count_reg);
            out_nan_reg   <= nan_reg;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.add_done = add_done;
    assign sts.z_nan    = nswdp_pkg::is_nan(mul_res);
    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg & ~result.ready;

    assign result.valid      = out_valid_reg;
    assign result.sum_bits   = out_sum_reg;
    assign result.count_bits = out_count_reg;
    assign result.nan_seen   = out_nan_reg;

endmodule

@@ rtl/core/nan_skipping_weighted_dot_product_core.sv @@
// NaN-skipping weighted dot product of one column pair in IEEE double precision.
// Each row runs x*y on the shared multiplier (four 27x27 partial products, then
// normalize and round), then z*w on the same unit, then sum and count updates
// back to back on one adder; a row whose x*y product is NaN ends after that
// multiply. The next row is taken once the controller is back in idle.
// A finished result waits in the output register and the block keeps taking rows;
// it holds only when a second last row is done before the first result is taken.
// NaN results come out as the canonical quiet NaN.
module nan_skipping_weighted_dot_product_core (
    input  logic        clk,
    input  logic        rst_n,
    nswdp_row_if.sink   row,
    nswdp_res_if.source result,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic            row_fire;
    logic            row_ready;
    nswdp_pkg::cmd_t cmd;
    nswdp_pkg::sts_t sts;

    assign row.ready = row_ready;
    assign row_fire  = row.valid & row_ready;

    nswdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_fire  (row_fire),
        .row_ready (row_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nswdp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_fire    (row_fire),
        .x_bits      (row.x_bits),
        .y_bits      (row.y_bits),
        .weight_bits (row.weight_bits),
        .last_row    (row.last_row),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .sts         (sts),
        .result      (result)
    );

endmodule

@@ rtl/core/nswdp_chk.sv @@
module nswdp_chk (
    input logic clk,
    input logic rst_n,
    input logic row_valid,
    input logic row_ready,
    input logic row_last,
    input logic res_valid,
    input logic res_ready
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (row_valid && row_ready && row_last) begin
            pend_next = pend_next + 2'd1;
        end
        if (res_valid && res_ready) begin
            pend_next = pend_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 2'd0;
        end
        else begin
            pend_reg <= pend_next;
        end
    end

    // a result only for a last row not yet answered
    a_res_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 2'd0)
        else $error("result word without a pending last row");

    // two pairs in flight: no more rows
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !row_ready)
        else $error("row taken with two results pending");

    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready |=> !row_ready)
        else $error("row taken while previous row in work");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

endmodule

bind nan_skipping_weighted_dot_product_core nswdp_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row.valid),
    .row_ready (row.ready),
    .row_last  (row.last_row),
    .res_valid (result.valid),
    .res_ready (result.ready)
);

@@ tb/nswdp_dot_checker.sv @@
`timescale 1ns / 1ps

module nswdp_dot_checker (
    input  logic  clk,
    input  logic  rst_n,
    nswdp_row_if  row,
    nswdp_res_if  result,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    output int    fails,
    output int    pending,
    output int    pairs_done,
    output int    nan_rows
);

    typedef struct packed {
        logic [63:0] sum_bits;
        logic [63:0] count_bits;
        logic        nan_seen;
    } pair_total_t;

    pair_total_t expected_totals[$];

    real  run_sum;
    real  run_count;
    logic run_nan;
    logic weights_on;

    function automatic logic word_is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic logic [63:0] to_word(input real r);
        logic [63:0] b;
        b = $realtobits(r);
        return word_is_nan(b) ? nswdp_pkg::CANON_NAN : b;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        real         z;
        real         w;
        pair_total_t got;
        pair_total_t want;
        if (!rst_n)
        begin
            run_sum    = 0.0;
            run_count  = 0.0;
            run_nan    = 1'b0;
            weights_on = 1'b0;
            fails      = 0;
            pending    = 0;
            pairs_done = 0;
            nan_rows   = 0;
            expected_totals.delete();
        end
        else
        begin
            if (cfg_we)
                weights_on = cfg_wdata;

            if (row.valid && row.ready)
            begin
                z = $bitstoreal(row.x_bits) * $bitstoreal(row.y_bits);
                w = weights_on ? $bitstoreal(row.weight_bits) : 1.0;
                if (word_is_nan($realtobits(z)))
                begin
                    run_nan = 1'b1;
                    nan_rows++;
                end
                else
                begin
                    run_sum   = run_sum + z * w;
                    run_count = run_count + w;
                end
                if (row.last_row)
                begin
                    expected_totals.push_back({to_word(run_sum), to_word(run_count), run_nan});
                    run_sum   = 0.0;
                    run_count = 0.0;
                    run_nan   = 1'b0;
                end
            end

            if (result.valid && result.ready)
            begin
                got = {result.sum_bits, result.count_bits, result.nan_seen};
                if (expected_totals.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word: sum %h count %h nan %b",
                                 got.sum_bits, got.count_bits, got.nan_seen);
                end
                else
                begin
                    want = expected_totals.pop_front();
                    pairs_done++;
                    if (got != want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("pair %0d mismatch: sum %h/%h count %h/%h nan %b/%b",
                                     pairs_done, want.sum_bits, got.sum_bits,
                                     want.count_bits, got.count_bits,
                                     want.nan_seen, got.nan_seen);
                    end
                end
            end
            pending = expected_totals.size();
        end
    end

endmodule

@@ tb/nan_skipping_weighted_dot_product_core_test.sv @@
`timescale 1ns / 1ps

module nan_skipping_weighted_dot_product_core_test;

    localparam logic [63:0] DBL_TWO   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] DBL_HALF  = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DBL_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_MAX   = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DBL_MINN  = 64'h0010_0000_0000_0000;
    localparam logic [63:0] DBL_MINS  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] DBL_NEG0  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SNAN      = 64'h7FF0_0000_0000_0001;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fails;
    int   pending;
    int   pairs_done;
    int   nan_rows;
    int   rows_sent;
    int   idle_cycles;
    bit   held;

    nswdp_row_if row_ch ();
    nswdp_res_if res_ch ();

    nan_skipping_weighted_dot_product_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    nswdp_dot_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .row        (row_ch),
        .result     (res_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fails      (fails),
        .pending    (pending),
        .pairs_done (pairs_done),
        .nan_rows   (nan_rows)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] pick_double();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return {$urandom, $urandom};
        if (r < 85)
            return {1'($urandom), 11'(1023 + $urandom_range(0, 20) - 10), $urandom, 20'($urandom)};
        case ($urandom_range(0, 9))
            0: return nswdp_pkg::DBL_ZERO;
            1: return DBL_NEG0;
            2: return DBL_INF;
            3: return {1'b1, DBL_INF[62:0]};
            4: return {1'($urandom), 11'h7FF, 1'($urandom), 19'($urandom), $urandom | 32'd1};
            5: return {1'($urandom), 11'd0, 20'($urandom), $urandom};
            6: return DBL_MAX;
            7: return DBL_MINN;
            8: return nswdp_pkg::DBL_ONE;
            default: return DBL_MINS;
        endcase
    endfunction

    task automatic send_row(input logic [63:0] x, input logic [63:0] y,
                            input logic [63:0] w, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_ch.valid       <= 1'b1;
        row_ch.x_bits      <= x;
        row_ch.y_bits      <= y;
        row_ch.weight_bits <= w;
        row_ch.last_row    <= last;
        @(posedge clk);
        while (!row_ch.ready)
            @(posedge clk);
        rows_sent++;
    endtask

    task automatic send_edge_rows();
        send_row(nswdp_pkg::DBL_ONE, nswdp_pkg::DBL_ONE, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(DBL_MAX, DBL_MAX, DBL_TWO, 1'b0);
        send_row(nswdp_pkg::DBL_ONE, DBL_TWO, DBL_HALF, 1'b1);
        send_row(DBL_INF, nswdp_pkg::DBL_ZERO, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(SNAN, nswdp_pkg::DBL_ONE, nswdp_pkg::DBL_ONE, 1'b0);
        send_row(64'h4008_0000_0000_0000, 64'hC000_0000_0000_0000, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(DBL_INF, DBL_TWO, nswdp_pkg::DBL_ZERO, 1'b1);
        send_row(DBL_TWO, 64'h4008_0000_0000_0000, nswdp_pkg::CANON_NAN, 1'b1);
        send_row(DBL_MINS, DBL_HALF, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(DBL_NEG0, 64'h4014_0000_0000_0000, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(ALL_ONES, nswdp_pkg::DBL_ZERO, ALL_ONES, 1'b1);
        send_row(DBL_MINN, DBL_MINN, nswdp_pkg::DBL_ONE, 1'b0);
        send_row({1'b1, DBL_MAX[62:0]}, DBL_MAX, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(DBL_INF, SNAN, nswdp_pkg::DBL_ONE, 1'b1);
        send_row(nswdp_pkg::DBL_ZERO, nswdp_pkg::DBL_ZERO, DBL_NEG0, 1'b1);
        send_row(DBL_TWO, nswdp_pkg::DBL_ONE, DBL_MAX, 1'b0);
        send_row(DBL_TWO, nswdp_pkg::DBL_ONE, DBL_MAX, 1'b1);
        send_row(nswdp_pkg::DBL_ZERO, nswdp_pkg::DBL_ZERO, nswdp_pkg::DBL_ZERO, 1'b1);
    endtask

    task automatic send_random_rows(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_row(pick_double(), pick_double(), pick_double(), i == len - 1);
            sent += len;
        end
    endtask

    task automatic settle_and_write(input logic v);
        row_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        row_ch.valid       = 1'b0;
        row_ch.x_bits      = '0;
        row_ch.y_bits      = '0;
        row_ch.weight_bits = '0;
        row_ch.last_row    = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        rows_sent          = 0;
        rst_n              = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_edge_rows();
        send_random_rows(300);
        settle_and_write(1'b1);
        send_edge_rows();
        send_random_rows(340);
        settle_and_write(1'b0);
        send_random_rows(300);
        settle_and_write(1'b1);
        send_random_rows(340);

        @(posedge clk);
        row_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d rows in %0d column pairs, %0d with NaN products, weights on and off.",
                 rows_sent, pairs_done, nan_rows);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial
    begin
        int taken;
        int r;
        taken        = 0;
        held         = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                taken++;
            r = $urandom_range(0, 99);
            if (taken == 4 && !held)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (700) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (r < 70)
                res_ch.ready <= 1'b1;
            else if (r < 95)
                res_ch.ready <= 1'b0;
            else
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
